### rtl/mpf_pkg.sv
`timescale 1ns / 1ps
package mpf_pkg;

  localparam int NUM_LEVELS  = 16;
  localparam int LEVEL_DEPTH = 16;
  localparam int ID_WIDTH    = 16;

  localparam int LVL_W  = $clog2(NUM_LEVELS);
  localparam int PTR_W  = $clog2(LEVEL_DEPTH);
  localparam int CNT_W  = $clog2(LEVEL_DEPTH + 1);
  localparam int STORE_DEPTH = NUM_LEVELS * LEVEL_DEPTH;
  localparam int ADDR_W = $clog2(STORE_DEPTH);

  // words parked between front and back
  localparam int QDEPTH = 2;
  localparam int QP_W   = $clog2(QDEPTH);
  localparam int QC_W   = $clog2(QDEPTH + 1);

  localparam logic KIND_ENQ = 1'b0;
  localparam logic KIND_DEQ = 1'b1;

  typedef enum logic [1:0] {
    OP_ENQ,
    OP_DEQ,
    OP_REJECT
  } op_t;

  typedef enum logic [1:0] {
    ST_ENQ   = 2'd0,
    ST_DEQ   = 2'd1,
    ST_EMPTY = 2'd2,
    ST_FULL  = 2'd3
  } status_t;

  typedef enum logic {
    S_IDLE,
    S_RD
  } state_t;

  typedef struct packed {
    op_t                 op;
    logic [ID_WIDTH-1:0] pid;
    logic [LVL_W-1:0]    lvl;
  } qword_t;

  function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(LEVEL_DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  function automatic logic [ADDR_W-1:0] store_addr(input logic [LVL_W-1:0] lvl,
                                                  input logic [PTR_W-1:0] p);
    return ADDR_W'(lvl) * ADDR_W'(LEVEL_DEPTH) + ADDR_W'(p);
  endfunction

endpackage

### rtl/mpf_ram.sv
`timescale 1ns / 1ps
module mpf_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### rtl/mpf_front.sv
`timescale 1ns / 1ps
module mpf_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_stall,
  input  logic            kind,
  input  logic [15:0]     proc_id,
  input  logic [3:0]      level,
  output logic            q_valid,
  output mpf_pkg::qword_t q_word,
  input  logic            q_pop
);

  mpf_pkg::qword_t              slots [mpf_pkg::QDEPTH];
  logic [mpf_pkg::QP_W-1:0]     wp;
  logic [mpf_pkg::QP_W-1:0]     rp;
  logic [mpf_pkg::QC_W-1:0]     fill;
  logic                         push;
  logic                         pop;
  mpf_pkg::qword_t              w;

  assign in_stall = (fill == mpf_pkg::QC_W'(mpf_pkg::QDEPTH));
  assign push     = in_valid && !in_stall;
  assign q_valid  = (fill != '0);
  assign pop      = q_pop && q_valid;
  assign q_word   = slots[rp];

  // classify: enqueue to a level past the last is refused up front
  always_comb begin
    w.pid = mpf_pkg::ID_WIDTH'(proc_id);
    w.lvl = mpf_pkg::LVL_W'(level);
    if (kind == mpf_pkg::KIND_DEQ) begin
      w.op = mpf_pkg::OP_DEQ;
    end else if (32'(level) < 32'(mpf_pkg::NUM_LEVELS)) begin
      w.op = mpf_pkg::OP_ENQ;
    end else begin
      w.op = mpf_pkg::OP_REJECT;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wp] <= w;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp   <= '0;
      rp   <= '0;
      fill <= '0;
    end else begin
      if (push) begin
        wp <= (wp == mpf_pkg::QP_W'(mpf_pkg::QDEPTH - 1)) ? '0 : wp + mpf_pkg::QP_W'(1);
      end
      if (pop) begin
        rp <= (rp == mpf_pkg::QP_W'(mpf_pkg::QDEPTH - 1)) ? '0 : rp + mpf_pkg::QP_W'(1);
      end
      if (push && !pop) begin
        fill <= fill + mpf_pkg::QC_W'(1);
      end else if (pop && !push) begin
        fill <= fill - mpf_pkg::QC_W'(1);
      end
    end
  end

endmodule

### rtl/mpf_back.sv
`timescale 1ns / 1ps
module mpf_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            q_valid,
  input  mpf_pkg::qword_t q_word,
  output logic            q_pop,
  output logic            out_valid,
  input  logic            out_stall,
  output logic [15:0]     out_id,
  output logic [3:0]      out_level,
  output logic [1:0]      status,
  output logic            now_empty
);

  mpf_pkg::state_t                  state;
  mpf_pkg::state_t                  state_next;

  logic [mpf_pkg::PTR_W-1:0]        head [mpf_pkg::NUM_LEVELS];
  logic [mpf_pkg::PTR_W-1:0]        tail [mpf_pkg::NUM_LEVELS];
  logic [mpf_pkg::CNT_W-1:0]        cnt  [mpf_pkg::NUM_LEVELS];
  logic [mpf_pkg::NUM_LEVELS-1:0]   nonempty;
  logic [mpf_pkg::NUM_LEVELS-1:0]   rem;

  logic [mpf_pkg::LVL_W-1:0]        sel;
  logic                             found;
  logic [mpf_pkg::LVL_W-1:0]        pend_level;
  logic                             pend_empty;

  logic                             out_free;
  logic                             load;
  logic                             enq_we;
  logic                             deq_we;
  logic [15:0]                      ld_id;
  logic [3:0]                       ld_level;
  mpf_pkg::status_t                 ld_status;
  mpf_pkg::status_t                 out_status;
  logic                             ld_empty;

  logic [mpf_pkg::ID_WIDTH-1:0]     ram_rd;

  mpf_ram #(
    .WIDTH (mpf_pkg::ID_WIDTH),
    .DEPTH (mpf_pkg::STORE_DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (enq_we),
    .wr_addr (mpf_pkg::store_addr(q_word.lvl, tail[q_word.lvl])),
    .wr_data (q_word.pid),
    .rd_en   (deq_we),
    .rd_addr (mpf_pkg::store_addr(sel, head[sel])),
    .rd_data (ram_rd)
  );

  assign out_free  = !out_valid || !out_stall;
  assign status    = out_status;

  always_comb begin
    for (int i = 0; i < mpf_pkg::NUM_LEVELS; i++) begin
      nonempty[i] = (cnt[i] != '0);
    end
  end

  // most urgent non-empty level
  always_comb begin
    sel   = '0;
    found = 1'b0;
    for (int i = mpf_pkg::NUM_LEVELS - 1; i >= 0; i--) begin
      if (nonempty[i]) begin
        sel   = mpf_pkg::LVL_W'(i);
        found = 1'b1;
      end
    end
  end

  always_comb begin
    rem = nonempty;
    if (cnt[sel] == mpf_pkg::CNT_W'(1)) begin
      rem[sel] = 1'b0;
    end
  end

  always_comb begin
    state_next = state;
    q_pop      = 1'b0;
    load       = 1'b0;
    enq_we     = 1'b0;
    deq_we     = 1'b0;
    ld_id      = '0;
    ld_level   = '0;
    ld_status  = mpf_pkg::ST_ENQ;
    ld_empty   = 1'b0;
    unique case (state)
      mpf_pkg::S_IDLE: begin
        if (q_valid && out_free) begin
          q_pop = 1'b1;
          load  = 1'b1;
          unique case (q_word.op)
            mpf_pkg::OP_ENQ: begin
              if (cnt[q_word.lvl] == mpf_pkg::CNT_W'(mpf_pkg::LEVEL_DEPTH)) begin
                ld_status = mpf_pkg::ST_FULL;
                ld_empty  = ~|nonempty;
              end else begin
                enq_we    = 1'b1;
                ld_status = mpf_pkg::ST_ENQ;
              end
            end
            mpf_pkg::OP_DEQ: begin
              if (!found) begin
                ld_status = mpf_pkg::ST_EMPTY;
                ld_empty  = 1'b1;
              end else begin
                // result shows up once the store read lands
                load       = 1'b0;
                deq_we     = 1'b1;
                state_next = mpf_pkg::S_RD;
              end
            end
            default: begin
              ld_status = mpf_pkg::ST_FULL;
              ld_empty  = ~|nonempty;
            end
          endcase
        end
      end
      mpf_pkg::S_RD: begin
        if (out_free) begin
          load       = 1'b1;
          ld_id      = 16'(ram_rd);
          ld_level   = 4'(pend_level);
          ld_status  = mpf_pkg::ST_DEQ;
          ld_empty   = pend_empty;
          state_next = mpf_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = mpf_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= mpf_pkg::S_IDLE;
      out_valid <= 1'b0;
      for (int i = 0; i < mpf_pkg::NUM_LEVELS; i++) begin
        head[i] <= '0;
        tail[i] <= '0;
        cnt[i]  <= '0;
      end
    end else begin
      state <= state_next;
      if (load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      if (enq_we) begin
        tail[q_word.lvl] <= mpf_pkg::next_ptr(tail[q_word.lvl]);
        cnt[q_word.lvl]  <= cnt[q_word.lvl] + mpf_pkg::CNT_W'(1);
      end
      if (deq_we) begin
        head[sel] <= mpf_pkg::next_ptr(head[sel]);
        cnt[sel]  <= cnt[sel] - mpf_pkg::CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_id     <= ld_id;
      out_level  <= ld_level;
      out_status <= ld_status;
      now_empty  <= ld_empty;
    end
    if (deq_we) begin
      pend_level <= sel;
      pend_empty <= ~|rem;
    end
  end

  a_pop_idle: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> state == mpf_pkg::S_IDLE)
    else $error("queue popped outside idle");

  a_rd_follows: assert property (@(posedge clk) disable iff (rst)
    deq_we |=> state == mpf_pkg::S_RD && !load || state == mpf_pkg::S_RD)
    else $error("dequeue issue not followed by read state");

  a_no_rw: assert property (@(posedge clk) disable iff (rst)
    !(enq_we && deq_we))
    else $error("store written and read in one step");

  a_deq_has_word: assert property (@(posedge clk) disable iff (rst)
    deq_we |-> found && q_valid)
    else $error("dequeue issued with nothing stored");

endmodule

### rtl/multilevel_priority_fifo.sv
// Multilevel priority FIFO of process identifiers: one FIFO per priority level,
// level 0 most urgent. An enqueue word appends to its level, a dequeue word
// returns the oldest identifier of the most urgent non-empty level; every
// input word yields exactly one result word, with now_empty flagging an empty
// store after the step. A two-word queue decouples the input side from the
// executing side, so input is taken while a result is stalled. Enqueues and
// refused or empty-store words finish in the idle state; a dequeue also passes
// through a read state for the registered read port of the identifier store.
`timescale 1ns / 1ps
module multilevel_priority_fifo (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        kind,
  input  logic [15:0] proc_id,
  input  logic [3:0]  level,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] out_id,
  output logic [3:0]  out_level,
  output logic [1:0]  status,
  output logic        now_empty
);

  logic            q_valid;
  logic            q_pop;
  mpf_pkg::qword_t q_word;

  mpf_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .kind     (kind),
    .proc_id  (proc_id),
    .level    (level),
    .q_valid  (q_valid),
    .q_word   (q_word),
    .q_pop    (q_pop)
  );

  mpf_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_word    (q_word),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_id    (out_id),
    .out_level (out_level),
    .status    (status),
    .now_empty (now_empty)
  );

endmodule
